// ----- design/frm_pkg.sv -----
// shared types and constants for the fraction reduction block
package frm_pkg;

    // width of the sideband that flags a zero denominator
    localparam int USER_W = 1;

    // which of the three divisions the shared divider is running
    typedef enum logic [1:0] {
        P_RN,
        P_RD,
        P_Q
    } t_pass;

endpackage

// ----- design/fraction_reduce_mixed.sv -----
// fraction reduction to lowest terms with whole part and remainder split
//
//  channel   dir  payload (low bits first)                                  sideband
//  s_axis    in   tdata: numerator, denominator, zero pad                    -
//  m_axis    out  tdata: reduced_numerator, reduced_denominator,             tuser: div_error
//                        whole_part, remainder_numerator, zero pad
//
// one fraction at a time: s_axis_tready is high only while the block is idle
// sequence: accept, pull out the common power of two, binary gcd, put the power of two
//   back, three divisions (reduced numerator, reduced denominator, whole part) through
//   one shared subtractor, 3 sign steps, output; a zero denominator goes straight to output
// a stalled result holds on m_axis and keeps the block from taking input
// reset (i_rst_n low, synchronous) returns the sequencer to idle with no result
module fraction_reduce_mixed
    import frm_pkg::*;
#(
    parameter int WIDTH = 32,
    localparam int IN_W = ((2 * WIDTH - 1 + 7) / 8) * 8,
    localparam int OUT_W = ((4 * WIDTH - 1 + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // slave side: numerator, denominator
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,   // numerator, denominator, pad
    // master side: one result transaction per fraction
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // reduced_numerator, reduced_denominator,
                                              // whole_part, remainder_numerator, pad
    output logic [USER_W-1:0] m_axis_tuser    // div_error
);

    localparam int CW = $clog2(WIDTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_GCD_EVEN,
        S_GCD_RED,
        S_GCD_FIX,
        S_DIV,
        S_SIGN_N,
        S_SIGN_Q,
        S_SIGN_R,
        S_OUT
    } t_state;

    t_state           r_state;
    t_pass            r_pass;
    logic             r_neg;
    logic             r_err;
    logic [WIDTH-1:0] r_a;      // gcd working operand
    logic [WIDTH-1:0] r_b;      // gcd working operand, then the gcd itself
    logic [CW-1:0]    r_k;      // common power of two pulled out of both
    logic [CW-1:0]    r_cnt;    // division step counter
    logic [WIDTH-1:0] r_rn;     // magnitude, then reduced numerator
    logic [WIDTH-2:0] r_rd;     // denominator, then reduced denominator
    logic [WIDTH-1:0] r_quo;    // dividend shifting out, quotient shifting in
    logic [WIDTH-1:0] r_rem;    // partial remainder

    logic [WIDTH-1:0] in_num;
    logic [WIDTH-2:0] in_den;
    logic [WIDTH-1:0] divisor;

    // the shared subtractor: negation, gcd difference and trial subtract
    logic [WIDTH:0]   op_a;
    logic [WIDTH:0]   op_b;
    logic [WIDTH+1:0] diff;
    logic             borrow;

    logic [WIDTH-1:0] quo_next;
    logic [WIDTH-1:0] rem_next;

    assign in_num = s_axis_tdata[WIDTH-1:0];
    assign in_den = s_axis_tdata[2*WIDTH-2:WIDTH];

    // gcd divides both inputs; the final division uses the reduced denominator
    assign divisor = (r_pass == P_Q) ? {1'b0, r_rd} : r_b;

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (r_state)
            S_IDLE: begin
                op_b = {1'b0, in_num};
            end
            S_GCD_RED: begin
                op_a = {1'b0, r_a};
                op_b = {1'b0, r_b};
            end
            S_DIV: begin
                op_a = {r_rem, r_quo[WIDTH-1]};
                op_b = {1'b0, divisor};
            end
            S_SIGN_N: begin
                op_b = {1'b0, r_rn};
            end
            S_SIGN_Q: begin
                op_b = {1'b0, r_quo};
            end
            S_SIGN_R: begin
                op_b = {1'b0, r_rem};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign diff   = {1'b0, op_a} - {1'b0, op_b};
    assign borrow = diff[WIDTH+1];

    // one restoring division step
    // partial remainder stays below the divisor, so the trial fits WIDTH bits
    assign rem_next = borrow ? op_a[WIDTH-1:0] : diff[WIDTH-1:0];
    assign quo_next = {r_quo[WIDTH-2:0], ~borrow};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= P_RN;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_neg <= in_num[WIDTH-1];
                        r_k   <= '0;
                        if (in_den == '0) begin
                            // zero denominator: flag it, all fields zero
                            r_err   <= 1'b1;
                            r_rn    <= '0;
                            r_rd    <= '0;
                            r_quo   <= '0;
                            r_rem   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            // magnitude; the most negative value comes out exact
                            r_err   <= 1'b0;
                            r_a     <= in_num[WIDTH-1] ? diff[WIDTH-1:0] : in_num;
                            r_rn    <= in_num[WIDTH-1] ? diff[WIDTH-1:0] : in_num;
                            r_b     <= {1'b0, in_den};
                            r_rd    <= in_den;
                            r_state <= S_GCD_EVEN;
                        end
                    end
                end
                S_GCD_EVEN: begin
                    // strip factors of two common to both operands
                    if (r_a == '0) begin
                        r_state <= S_GCD_FIX;
                    end else if (!r_a[0] && !r_b[0]) begin
                        r_a <= r_a >> 1;
                        r_b <= r_b >> 1;
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_state <= S_GCD_RED;
                    end
                end
                S_GCD_RED: begin
                    // binary gcd: drop lone twos, subtract the smaller odd value
                    if (r_a == '0) begin
                        r_state <= S_GCD_FIX;
                    end else if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                    end else if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                    end else if (borrow) begin
                        r_a <= r_b;
                        r_b <= r_a;
                    end else begin
                        r_a <= diff[WIDTH-1:0];
                    end
                end
                S_GCD_FIX: begin
                    // put the common power of two back into the gcd
                    if (r_k != '0) begin
                        r_b <= r_b << 1;
                        r_k <= r_k - 1'b1;
                    end else begin
                        r_pass  <= P_RN;
                        r_quo   <= r_rn;
                        r_rem   <= '0;
                        r_cnt   <= CW'(WIDTH - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt != '0) begin
                        r_quo <= quo_next;
                        r_rem <= rem_next;
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_cnt <= CW'(WIDTH - 1);
                        case (r_pass)
                            P_RN: begin
                                r_rn   <= quo_next;
                                r_quo  <= {1'b0, r_rd};
                                r_rem  <= '0;
                                r_pass <= P_RD;
                            end
                            P_RD: begin
                                r_rd   <= quo_next[WIDTH-2:0];
                                r_quo  <= r_rn;
                                r_rem  <= '0;
                                r_pass <= P_Q;
                            end
                            default: begin
                                r_quo   <= quo_next;
                                r_rem   <= rem_next;
                                r_pass  <= P_RN;
                                r_state <= S_SIGN_N;
                            end
                        endcase
                    end
                end
                S_SIGN_N: begin
                    if (r_neg) begin
                        r_rn <= diff[WIDTH-1:0];
                    end
                    r_state <= S_SIGN_Q;
                end
                S_SIGN_Q: begin
                    if (r_neg) begin
                        r_quo <= diff[WIDTH-1:0];
                    end
                    r_state <= S_SIGN_R;
                end
                S_SIGN_R: begin
                    if (r_neg) begin
                        r_rem <= diff[WIDTH-1:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = OUT_W'({r_rem, r_quo, r_rd, r_rn});
    assign m_axis_tuser  = USER_W'(r_err);

endmodule

// ----- design/frm_check.sv -----
// port-level checker for the fraction reduction block, with its bind
module frm_check
    import frm_pkg::*;
#(
    parameter int WIDTH = 32,
    localparam int OUT_W = ((4 * WIDTH - 1 + 7) / 8) * 8
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_W-1:0]  m_axis_tdata,
    input logic [USER_W-1:0] m_axis_tuser
);

    // never takes a new fraction while a result is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // an accepted fraction makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("block still ready after accepting a fraction");

    // a zero denominator result carries all zero fields
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("error result with nonzero fields");

    // one result per fraction: nothing more right after a taken result
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("result repeated after transaction");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind fraction_reduce_mixed frm_check #(.WIDTH(WIDTH)) u_frm_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- verif/fraction_reduce_mixed_checker.sv -----
`timescale 1ns / 1ps
// scoreboard for the fraction reduction block: predicts each result and compares it
module fraction_reduce_mixed_checker
    import frm_pkg::*;
#(
    parameter int WIDTH = 32,
    localparam int IN_W = ((2 * WIDTH - 1 + 7) / 8) * 8,
    localparam int OUT_W = ((4 * WIDTH - 1 + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [IN_W-1:0]   i_s_tdata,     // numerator, denominator, pad
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [OUT_W-1:0]  i_m_tdata,     // reduced_numerator, reduced_denominator,
                                             // whole_part, remainder_numerator, pad
    input  logic [USER_W-1:0] i_m_tuser,     // div_error
    output int                o_mismatch_count,
    output int                o_pending
);

    typedef struct {
        logic [WIDTH-1:0] in_num;
        logic [WIDTH-2:0] in_den;
        logic [WIDTH-1:0] red_num;
        logic [WIDTH-2:0] red_den;
        logic [WIDTH-1:0] whole;
        logic [WIDTH-1:0] rem_num;
        logic             div_err;
    } t_fraction;

    t_fraction expected_fractions[$];
    int        mismatch_count;

    // two's complement of a magnitude when the numerator was negative
    function automatic logic [WIDTH-1:0] with_sign(logic [WIDTH-1:0] mag, logic neg);
        return neg ? (~mag + 1'b1) : mag;
    endfunction

    function automatic t_fraction reduce_fraction(logic [WIDTH-1:0] num,
                                                  logic [WIDTH-2:0] den);
        t_fraction        f;
        logic             neg;
        logic [WIDTH-1:0] mag, den_w, a, b, t, g, rn, rd;
        f.in_num = num;
        f.in_den = den;
        f.red_num = '0;
        f.red_den = '0;
        f.whole = '0;
        f.rem_num = '0;
        f.div_err = 1'b0;
        if (den == '0) begin
            f.div_err = 1'b1;
            return f;
        end
        neg = num[WIDTH-1];
        // the most negative numerator gives exactly 2^(WIDTH-1) here
        mag = neg ? (~num + 1'b1) : num;
        den_w = {1'b0, den};
        a = mag;
        b = den_w;
        while (b != '0) begin
            t = a % b;
            a = b;
            b = t;
        end
        g = a;
        rn = mag / g;
        rd = den_w / g;
        f.red_num = with_sign(rn, neg);
        f.red_den = rd[WIDTH-2:0];
        f.whole = with_sign(rn / rd, neg);
        f.rem_num = with_sign(rn % rd, neg);
        return f;
    endfunction

    always @(posedge i_clk) begin
        t_fraction        exp_f;
        logic [WIDTH-1:0] got_num, got_whole, got_rem;
        logic [WIDTH-2:0] got_den;
        logic             got_err;
        if (!i_rst_n) begin
            expected_fractions.delete();
            mismatch_count = 0;
        end else begin
            // input transaction: predict its result
            if (i_s_tvalid && i_s_tready)
                expected_fractions.insert(expected_fractions.size(),
                    reduce_fraction(i_s_tdata[WIDTH-1:0], i_s_tdata[2*WIDTH-2:WIDTH]));

            // output transaction: compare with the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                got_num   = i_m_tdata[WIDTH-1:0];
                got_den   = i_m_tdata[2*WIDTH-2:WIDTH];
                got_whole = i_m_tdata[3*WIDTH-2:2*WIDTH-1];
                got_rem   = i_m_tdata[4*WIDTH-2:3*WIDTH-1];
                got_err   = i_m_tuser[0];
                if (expected_fractions.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: rn=%0d rd=%0d whole=%0d rem=%0d err=%0b",
                                 $signed(got_num), got_den, $signed(got_whole),
                                 $signed(got_rem), got_err);
                end else begin
                    exp_f = expected_fractions.pop_front();
                    if (got_num !== exp_f.red_num || got_den !== exp_f.red_den ||
                        got_whole !== exp_f.whole || got_rem !== exp_f.rem_num ||
                        got_err !== exp_f.div_err) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch for %0d/%0d", $signed(exp_f.in_num),
                                     exp_f.in_den);
                            $display("  expected rn=%0d rd=%0d whole=%0d rem=%0d err=%0b",
                                     $signed(exp_f.red_num), exp_f.red_den,
                                     $signed(exp_f.whole), $signed(exp_f.rem_num),
                                     exp_f.div_err);
                            $display("  actual   rn=%0d rd=%0d whole=%0d rem=%0d err=%0b",
                                     $signed(got_num), got_den, $signed(got_whole),
                                     $signed(got_rem), got_err);
                        end
                    end
                end
            end
        end
        o_mismatch_count <= mismatch_count;
        o_pending <= expected_fractions.size();
    end

endmodule

// ----- verif/fraction_reduce_mixed_tb.sv -----
`timescale 1ns / 1ps
// testbench top for the fraction reduction block: stimulus, output pacing and verdict
module fraction_reduce_mixed_tb;
    import frm_pkg::*;

    localparam int WIDTH = 32;
    localparam int IN_W = ((2 * WIDTH - 1 + 7) / 8) * 8;
    localparam int OUT_W = ((4 * WIDTH - 1 + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 925;
    // quiet time after the last result, a bit more than one fraction's worth of work
    localparam int DRAIN_CYCLES = 400;
    // long receiver hold-off, counted from the first clock
    localparam int HOLD_START = 15000;
    localparam int HOLD_LEN = 3000;
    localparam logic [WIDTH-1:0] NUM_MAX = 32'h7fff_ffff;
    localparam logic [WIDTH-1:0] NUM_MIN = 32'h8000_0001;
    localparam logic [WIDTH-1:0] NUM_MOST_NEG = 32'h8000_0000;
    localparam logic [WIDTH-2:0] DEN_MAX = 31'h7fff_ffff;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic [USER_W-1:0] m_axis_tuser;
    int                mismatches;
    int                pending;

    fraction_reduce_mixed #(
        .WIDTH(WIDTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    fraction_reduce_mixed_checker #(
        .WIDTH(WIDTH)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_axis_tvalid),
        .i_s_tready       (s_axis_tready),
        .i_s_tdata        (s_axis_tdata),
        .i_m_tvalid       (m_axis_tvalid),
        .i_m_tready       (m_axis_tready),
        .i_m_tdata        (m_axis_tdata),
        .i_m_tuser        (m_axis_tuser),
        .o_mismatch_count (mismatches),
        .o_pending        (pending)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // offer one fraction from the falling edge and hold it until the transaction;
    // tvalid stays high afterwards so a back-to-back item follows without a dip
    task automatic push_fraction(input logic [WIDTH-1:0] num, input logic [WIDTH-2:0] den);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, den, num};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // receiver: segments of random pacing, plus one long hold-off so the block
    // sits on a finished result while the sender keeps offering
    initial begin
        int cyc;
        int seg_left;
        int mode;
        cyc = 0;
        seg_left = 0;
        mode = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (seg_left == 0) begin
                mode = $urandom_range(0, 3);
                seg_left = $urandom_range(50, 2000);
            end
            seg_left--;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 7) == 0);
                    default: m_axis_tready <= ((cyc % 16) < 3);
                endcase
            end
        end
    end

    // stimulus and verdict
    initial begin
        logic [WIDTH-1:0] num;
        logic [WIDTH-2:0] den;
        logic [WIDTH-1:0] fa, fb, fg;
        int               sent;
        int               burst;
        int               gap;
        int               pick;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes and the named special cases
        push_fraction(32'd0, 31'd1);                  // zero numerator
        push_fraction(32'd0, DEN_MAX);                // zero numerator, large denominator
        push_fraction(32'd0, 31'd0);                  // zero over zero
        push_fraction(32'd5, 31'd0);                  // zero denominator
        push_fraction(NUM_MIN, 31'd0);                // zero denominator, negative
        push_fraction(NUM_MAX, 31'd1);
        push_fraction(NUM_MIN, 31'd1);
        push_fraction(NUM_MAX, DEN_MAX);              // reduces to one
        push_fraction(NUM_MIN, DEN_MAX);              // reduces to minus one
        push_fraction(NUM_MOST_NEG, 31'd1);           // most negative numerator
        push_fraction(NUM_MOST_NEG, 31'h4000_0000);   // most negative over power of two
        push_fraction(NUM_MOST_NEG, DEN_MAX);
        push_fraction(NUM_MOST_NEG, 31'd0);
        push_fraction(32'd1, DEN_MAX);
        push_fraction(32'hffff_ffff, DEN_MAX);        // minus one
        push_fraction(32'd6, 31'd4);
        push_fraction(-32'sd6, 31'd4);
        push_fraction(-32'sd7, 31'd2);
        push_fraction(32'd7, 31'd7);
        push_fraction(-32'sd12, 31'd18);              // proper fraction, negative
        push_fraction(32'd100, 31'd7);
        push_fraction(-32'sd100, 31'd7);
        push_fraction(32'h4000_0000, 31'h2000_0000);
        push_fraction(32'h7fff_fffe, 31'h4000_0000);

        // random: bursts with gaps of random length
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 16);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        num = $urandom;
                        den = 31'($urandom);
                    end
                    2: begin
                        // shared factor, small cofactors
                        fg = $urandom_range(1, 65535);
                        fa = $urandom_range(0, 32767);
                        fb = $urandom_range(1, 32767);
                        num = fa * fg;
                        den = 31'(fb * fg);
                        if ($urandom_range(0, 1)) num = -num;
                    end
                    3: begin
                        // large shared factor
                        fg = $urandom_range(1, 1 << 20);
                        fa = $urandom_range(0, 2047);
                        fb = $urandom_range(1, 2047);
                        num = fa * fg;
                        den = 31'(fb * fg);
                        if ($urandom_range(0, 1)) num = -num;
                    end
                    4: begin
                        num = $urandom_range(0, 200);
                        if ($urandom_range(0, 1)) num = -num;
                        den = 31'($urandom_range(1, 50));
                    end
                    5: begin
                        // powers of two exercise the shift-back of the gcd
                        num = $urandom >> $urandom_range(0, 31);
                        den = 31'd1 << $urandom_range(0, 30);
                    end
                    6: begin
                        num = $urandom;
                        den = 31'($urandom_range(1, 1000));
                    end
                    7: begin
                        num = $urandom_range(0, 1000);
                        if ($urandom_range(0, 1)) num = -num;
                        den = 31'($urandom);
                    end
                    8: begin
                        pick = $urandom_range(0, 5);
                        case (pick)
                            0: num = 32'd0;
                            1: num = 32'd1;
                            2: num = 32'hffff_ffff;
                            3: num = NUM_MAX;
                            4: num = NUM_MIN;
                            default: num = NUM_MOST_NEG;
                        endcase
                        pick = $urandom_range(0, 3);
                        case (pick)
                            0: den = 31'd1;
                            1: den = DEN_MAX;
                            2: den = 31'd0;
                            default: den = 31'($urandom);
                        endcase
                    end
                    default: begin
                        if ($urandom_range(0, 1)) begin
                            num = $urandom;
                            den = 31'd0;
                        end else begin
                            num = 32'd0;
                            den = 31'($urandom);
                        end
                    end
                endcase
                push_fraction(num, den);
                sent++;
            end
            pick = $urandom_range(0, 9);
            if (pick < 4 || pick == 9)
                gap = 0;
            else if (pick < 8)
                gap = $urandom_range(1, 20);
            else
                gap = $urandom_range(21, 250);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // drain: every prediction answered, then let the block settle
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog: far beyond the slowest correct run
    initial begin
        #30_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
